>>> rtl/tac_pkg.sv
// Shared types and constants for the thermistor sample to Celsius converter.
// Holds the knee table, the conversion constants, the FSM type and the ALU result.
// Depends on nothing.
package tac_pkg;

	// knee table: halved sample at 50..100 C in 5 C steps, zero past the last entry
	localparam int TBL_CAP   = 32;
	localparam int TBL_IDX_W = 5;
	localparam int ENTRY_W   = 8;

	localparam logic [ENTRY_W-1:0] KNEE_TABLE [TBL_CAP] = '{
		0: 8'd203, 1: 8'd178, 2: 8'd157, 3: 8'd138, 4: 8'd121, 5: 8'd106,
		6: 8'd93,  7: 8'd81,  8: 8'd70,  9: 8'd61,  10: 8'd53,
		default: 8'd0
	};

	// region limits and line fit
	localparam int LINE_START_SAMPLE = 407;
	localparam int CLAMP_SAMPLE      = 107;
	localparam int BASE_TEMP         = 50;
	localparam int CLAMP_TEMP        = 100;
	localparam int TEMP_STEP         = 5;
	localparam int LINE_ROUND        = 16;
	localparam int LINE_SHIFT        = 5;

	// shared subtractor: wide enough for the interpolation remainder (< 5.5 * 255)
	localparam int ALU_W = 11;

	typedef struct packed {
		logic             borrow;
		logic [ALU_W-1:0] diff;
	} tac_alu_res_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_GAP    = 6'b000100,
		ST_NUM    = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_DONE   = 6'b100000
	} tac_state_t;

endpackage

>>> rtl/tac_sample_if.sv
// Input channel of the converter: valid/ready handshake with one raw ADC sample.
// Depends on nothing.
interface tac_sample_if #(
	parameter int ADC_BITS = 10
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> rtl/tac_temp_if.sv
// Output channel of the converter: valid/ready handshake with one temperature word.
// Depends on nothing.
interface tac_temp_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] temp_celsius;

	modport source (output valid, output temp_celsius, input ready);
	modport sink   (input valid, input temp_celsius, output ready);
endinterface

>>> rtl/tac_alu.sv
// Shared subtract/compare unit of the converter.
// Depends on tac_pkg.
module tac_alu
	import tac_pkg::*;
(
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output tac_alu_res_t     res
);

	// borrow set means a < b
	assign {res.borrow, res.diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> rtl/thermistor_adc_to_celsius_core.sv
// Thermistor ADC sample to whole degrees Celsius, one word out per word in.
// Line and clamp region results pass through the result register and then the output
// register; table region results first wait for the binary search and the 3-step
// restoring division on one shared subtractor.
// Samples are handled one at a time; the next is taken while a result waits.
// arst_n clears the sequencer and the output valid; datapath registers are not reset.
module thermistor_adc_to_celsius_core
	import tac_pkg::*;
#(
	parameter int TABLE_ENTRIES = 11,
	parameter int ADC_BITS      = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	tac_sample_if.sink   sample,
	tac_temp_if.source   temp
);

	// search bounds must hold the entry count itself
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	// result width covers the line region low end and the table region high end
	localparam int RW = ADC_BITS + 2;
	localparam int DW = ADC_BITS + 2;
	localparam int FALLBACK_TEMP = BASE_TEMP + TEMP_STEP * (TABLE_ENTRIES - 1);

	localparam logic signed [RW-1:0] SAT_MIN = RW'(-128);
	localparam logic signed [RW-1:0] SAT_MAX = RW'(127);

	tac_state_t state_q, state_d;

	logic [CW-1:0]          lo_q, lo_d;       // lowest index still possible for first entry < half
	logic [CW-1:0]          hi_q, hi_d;
	logic [ENTRY_W-1:0]     half_q, half_d;
	logic [ENTRY_W-1:0]     gap_q, gap_d;
	logic [ALU_W-1:0]       rem_q, rem_d;
	logic [1:0]             k_q, k_d;
	logic [2:0]             quo_q, quo_d;
	logic signed [RW-1:0]   res_q, res_d;

	logic                   ovalid_q;
	logic signed [7:0]      odata_q;
	logic                   out_load;

	logic [ADC_BITS-1:0]    s;
	logic [DW-1:0]          line_off;
	logic [DW-1:0]          line_prod;
	logic [DW-1:0]          line_drop;
	logic [ENTRY_W-1:0]     s_half;

	logic [CW:0]            mid_sum;
	logic [CW-1:0]          mid;
	logic [CW-1:0]          idx_up;
	logic [ENTRY_W-1:0]     ent_mid;
	logic [ENTRY_W-1:0]     ent_up;
	logic [ENTRY_W-1:0]     ent_dn;
	logic [2:0]             quo_next;
	logic [ALU_W-1:0]       gap_sh;

	logic [ALU_W-1:0]       alu_a;
	logic [ALU_W-1:0]       alu_b;
	tac_alu_res_t           alu_res;

	tac_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// Line region: drop = ((s - 407) * 3 + 16) >> 5, multiply by 3 as shift and add.
	assign s         = sample.adc_sample;
	assign line_off  = DW'(s) - DW'(LINE_START_SAMPLE);
	assign line_prod = (line_off << 1) + line_off + DW'(LINE_ROUND);
	assign line_drop = line_prod >> LINE_SHIFT;
	// middle region samples stay below 407, so the halved value fits a table entry
	assign s_half    = s[ENTRY_W:1];

	// search midpoint and the bracketing pair around the found index
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign idx_up  = lo_q - CW'(1);
	assign ent_mid = KNEE_TABLE[TBL_IDX_W'(mid)];
	assign ent_up  = KNEE_TABLE[TBL_IDX_W'(idx_up)];
	assign ent_dn  = KNEE_TABLE[TBL_IDX_W'(lo_q)];
	assign gap_sh  = ALU_W'(gap_q) << k_q;

	assign sample.ready = (state_q == ST_IDLE);

	// Route operands of the shared subtractor by sequencer step.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			ST_SEARCH: begin
				alu_a = ALU_W'(ent_mid);
				alu_b = ALU_W'(half_q);
			end
			ST_GAP: begin
				alu_a = ALU_W'(ent_up);
				alu_b = ALU_W'(ent_dn);
			end
			ST_NUM: begin
				alu_a = ALU_W'(ent_up);
				alu_b = ALU_W'(half_q);
			end
			ST_DIV: begin
				alu_a = rem_q;
				alu_b = gap_sh;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	// restoring division: set quotient bit k when the shifted gap fits
	always_comb begin
		quo_next = quo_q;
		if (!alu_res.borrow) begin
			quo_next[k_q] = 1'b1;
		end
	end

	// Sequencer: decode the region, binary-search the table, then interpolate.
	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		half_d  = half_q;
		gap_d   = gap_q;
		rem_d   = rem_q;
		k_d     = k_q;
		quo_d   = quo_q;
		res_d   = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					half_d = s_half;
					priority if (s >= ADC_BITS'(LINE_START_SAMPLE)) begin
						res_d   = signed'(RW'(BASE_TEMP) - RW'(line_drop));
						state_d = ST_DONE;
					end else if (s <= ADC_BITS'(CLAMP_SAMPLE)) begin
						res_d   = RW'(CLAMP_TEMP);
						state_d = ST_DONE;
					end else if (s_half > KNEE_TABLE[0]) begin
						// above the first entry: nothing brackets it
						res_d   = RW'(BASE_TEMP);
						state_d = ST_DONE;
					end else begin
						lo_d    = CW'(1);
						hi_d    = CW'(TABLE_ENTRIES);
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (lo_q == hi_q) begin
					if (lo_q == CW'(TABLE_ENTRIES)) begin
						// every entry is at or above the halved sample
						res_d   = RW'(FALLBACK_TEMP);
						state_d = ST_DONE;
					end else begin
						state_d = ST_GAP;
					end
				end else if (alu_res.borrow) begin
					hi_d = mid;
				end else begin
					lo_d = mid + CW'(1);
				end
			end
			ST_GAP: begin
				gap_d   = alu_res.diff[ENTRY_W-1:0];
				state_d = ST_NUM;
			end
			ST_NUM: begin
				// numerator = (upper entry - half) * 5 + gap / 2
				rem_d   = ALU_W'({alu_res.diff[ENTRY_W-1:0], 2'b00})
				        + ALU_W'(alu_res.diff[ENTRY_W-1:0])
				        + ALU_W'(gap_q[ENTRY_W-1:1]);
				k_d     = 2'd2;
				quo_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!alu_res.borrow) begin
					rem_d = alu_res.diff;
				end
				quo_d = quo_next;
				if (k_q == 2'd0) begin
					res_d   = signed'(RW'(BASE_TEMP) + (RW'(idx_up) << 2) + RW'(idx_up)
					                  + RW'(quo_next));
					state_d = ST_DONE;
				end else begin
					k_d = k_q - 2'd1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hand the result over once the output register is free or being drained
	assign out_load = (state_q == ST_DONE) && (!ovalid_q || temp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		half_q <= half_d;
		gap_q  <= gap_d;
		rem_q  <= rem_d;
		k_q    <= k_d;
		quo_q  <= quo_d;
		res_q  <= res_d;
	end

	// Output register: saturate to the 8-bit field, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (temp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			priority if (res_q < SAT_MIN) begin
				odata_q <= 8'sh80;
			end else if (res_q > SAT_MAX) begin
				odata_q <= 8'sh7F;
			end else begin
				odata_q <= res_q[7:0];
			end
		end
	end

	assign temp.valid        = ovalid_q;
	assign temp.temp_celsius = odata_q;

endmodule

>>> sim/tac_temp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the thermistor sample to Celsius converter: watches both channels,
// predicts each temperature word and compares it with what leaves the block.
// Depends on tac_sample_if and tac_temp_if.
module tac_temp_checker #(
	parameter int TABLE_ENTRIES = 11,
	parameter int ADC_BITS      = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	tac_sample_if smp,
	tac_temp_if   tmp,
	output int    fail_count,
	output int    pending_words
);

	localparam int KNEE_CAP   = 32;
	localparam int LINE_START = 407;
	localparam int CLAMP_EDGE = 107;
	localparam int BASE_C     = 50;
	localparam int CLAMP_C    = 100;
	localparam int STEP_C     = 5;

	localparam int KNEE [KNEE_CAP] = '{
		0: 203, 1: 178, 2: 157, 3: 138, 4: 121, 5: 106,
		6: 93, 7: 81, 8: 70, 9: 61, 10: 53, default: 0
	};

	logic signed [7:0] celsius_q [$];

	function automatic logic signed [7:0] celsius_of(input logic [ADC_BITS-1:0] raw);
		int s;
		int t;
		int half;
		int n;
		int gap;
		bit found;
		s     = int'(raw);
		found = 1'b0;
		t     = 0;
		n     = (TABLE_ENTRIES > KNEE_CAP) ? KNEE_CAP : ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
		if (s >= LINE_START) begin
			t = BASE_C - ((s - LINE_START) * 3 + 16) / 32;
		end else if (s <= CLAMP_EDGE) begin
			t = CLAMP_C;
		end else begin
			half = s / 2;
			for (int i = 0; i + 1 < n; i++) begin
				if (!found && KNEE[i] >= half && KNEE[i+1] < half) begin
					gap   = KNEE[i] - KNEE[i+1];
					t     = BASE_C + STEP_C * i + ((KNEE[i] - half) * STEP_C + gap / 2) / gap;
					found = 1'b1;
				end
			end
			// halved sample outside the table: pin to the nearer end, no step
			if (!found)
				t = (half > KNEE[0]) ? BASE_C : BASE_C + STEP_C * (n - 1);
		end
		if (t < -128)
			t = -128;
		if (t > 127)
			t = 127;
		return t[7:0];
	endfunction

	initial begin
		fail_count    = 0;
		pending_words = 0;
	end

	always @(posedge clk) begin
		logic signed [7:0] want;
		if (arst_n) begin
			if (smp.valid && smp.ready)
				celsius_q.push_back(celsius_of(smp.adc_sample));
			if (tmp.valid && tmp.ready) begin
				if (celsius_q.size() == 0) begin
					$error("temp_celsius: word %0d with no sample waiting", tmp.temp_celsius);
					fail_count++;
				end else begin
					want = celsius_q.pop_front();
					if (tmp.temp_celsius !== want) begin
						$error("temp_celsius mismatch: expected %0d, actual %0d",
							want, tmp.temp_celsius);
						fail_count++;
					end
				end
			end
			pending_words = celsius_q.size();
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, sample stimulus and output back-pressure.
// Depends on tac_pkg, both channel interfaces, the core and tac_temp_checker.
module tb_top;

	localparam int ADC_BITS      = 10;
	localparam int TABLE_ENTRIES = 11;
	localparam int RAND_WORDS    = 1300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_words;
	int   cycle_count;

	// idle odds in percent: sender gaps and receiver stalls, changed per phase
	int   send_idle_pct;
	int   recv_stall_pct;

	tac_sample_if #(.ADC_BITS(ADC_BITS)) sample_ch ();
	tac_temp_if                          temp_ch ();

	thermistor_adc_to_celsius_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ADC_BITS     (ADC_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.temp  (temp_ch)
	);

	tac_temp_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ADC_BITS     (ADC_BITS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (sample_ch),
		.tmp          (temp_ch),
		.fail_count   (fail_count),
		.pending_words(pending_words)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Drive the sink side: stall at random at the current odds.
	always @(posedge clk) begin
		if (!arst_n)
			temp_ch.ready <= 1'b0;
		else
			temp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: a hung handshake or a lost word ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one word and hold it until the core takes it. Valid stays high
	// across back-to-back words, so it gets exactly one assignment per edge.
	task automatic push_sample(input logic [ADC_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.adc_sample <= s;
		do
			@(posedge clk);
		while (!sample_ch.ready);
	endtask

	// Weight the draw toward the table region, where the search and the
	// division live; keep the line and clamp regions and full-range noise too.
	function automatic logic [ADC_BITS-1:0] pick_sample();
		logic [ADC_BITS-1:0] s;
		case ($urandom_range(9))
			0:       s = ADC_BITS'($urandom_range(107));
			1, 2:    s = ADC_BITS'($urandom_range(1023, 407));
			9:       s = ADC_BITS'($urandom);
			default: s = ADC_BITS'($urandom_range(406, 108));
		endcase
		return s;
	endfunction

	// Directed words: field extremes, region edges, exact table hits on both
	// halving parities, single-bit and alternating patterns.
	localparam int N_DIRECTED = 25;
	localparam logic [ADC_BITS-1:0] DIRECTED [N_DIRECTED] = '{
		10'd0,   10'd1023, 10'd107, 10'd108, 10'd109, 10'd406, 10'd407, 10'd408,
		10'd406, 10'd357, 10'd314, 10'd277, 10'd242, 10'd213, 10'd186, 10'd163,
		10'd140, 10'd123, 10'd110, 10'd512, 10'd341, 10'd682, 10'd438, 10'd439,
		10'd200
	};

	initial begin
		cycle_count          = 0;
		send_idle_pct        = 14;
		recv_stall_pct       = 74;
		sample_ch.valid      = 1'b0;
		sample_ch.adc_sample = '0;
		temp_ch.ready        = 1'b0;
		arst_n               = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 1: light sender gaps, heavy receiver stalls
		foreach (DIRECTED[i])
			push_sample(DIRECTED[i]);
		for (int i = 0; i < RAND_WORDS / 3; i++)
			push_sample(pick_sample());

		// phase 2: swap the odds
		send_idle_pct  = 74;
		recv_stall_pct = 14;
		for (int i = 0; i < RAND_WORDS / 3; i++)
			push_sample(pick_sample());

		// phase 3: full rate on both sides
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < RAND_WORDS - 2 * (RAND_WORDS / 3); i++)
			push_sample(pick_sample());
		sample_ch.valid <= 1'b0;

		// Drain: sample the count away from the edge the checker updates on.
		@(negedge clk);
		while (pending_words != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
